// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the image filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define CFI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define CFI_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `CFI_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ===== rtl/cfi_pkg.sv =====
// ----------------------------------------------------------------------------
// Image filter package
// Types, widths and register codes shared by the 3x3 filter modules.
// ----------------------------------------------------------------------------
package cfi_pkg;

   // Field and register widths.
   localparam int PIXEL_W    = 8;
   localparam int COEF_W     = 16;
   localparam int FILT_W     = 28;
   localparam int KROW_W     = 48;
   localparam int GEOM_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int TAPS       = 3;

   // Output queue geometry.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   // Geometry limits and reset values.
   localparam int               MIN_GEOM   = 3;
   localparam logic [GEOM_W-1:0] DEF_WIDTH  = 8'd100;
   localparam logic [GEOM_W-1:0] DEF_HEIGHT = 8'd100;

   // Item kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_KERNEL_TOP    = 3'd2,
      REG_KERNEL_MIDDLE = 3'd3,
      REG_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

   typedef logic [PIXEL_W-1:0]        pixel_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [FILT_W-1:0]  filt_type;

   // One window column, top row in element 0.
   typedef pixel_type [TAPS-1:0] column_type;
   // Coefficients for one window column, top row in element 0.
   typedef coef_type [TAPS-1:0]  coef_col_type;

   // One result transaction as held in the output queue.
   typedef struct packed {
      logic signed [FILT_W-1:0] filtered;
      logic                     frame_end;
   } result_type;

   // Handshake between the control logic and the output queue.
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

endpackage

// ===== rtl/cfi_channels.sv =====
// ----------------------------------------------------------------------------
// Image filter channels
// Valid/ready interfaces for the pixel, result and register channels.
// ----------------------------------------------------------------------------
interface cfi_req_if import cfi_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            kind;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, kind, pixel, input ready);
   modport sink   (input valid, kind, pixel, output ready);
endinterface

interface cfi_rsp_if import cfi_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [FILT_W-1:0] filtered;
   logic                     frame_end;

   modport source (output valid, filtered, frame_end, input ready);
   modport sink   (input valid, filtered, frame_end, output ready);
endinterface

interface cfi_csr_if import cfi_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/cfi_cell.sv =====
// ----------------------------------------------------------------------------
// Window column cell
// Holds one column of the 3x3 window, passes it to the left neighbor on each
// shift and registers the weighted sum of its three pixels.
// ----------------------------------------------------------------------------
module cfi_cell import cfi_pkg::*; (
   input  logic         clock,
   input  logic         shift_en,
   input  column_type   column_from_right,
   input  coef_col_type coef,
   output column_type   column_to_left,
   output filt_type     partial
);

   column_type column_ff, column_in;
   filt_type   partial_ff, partial_in;

   // Column shift and the three products of this column.
   always_comb begin
      logic signed [PIXEL_W+COEF_W:0] prod [TAPS];
      filt_type                       acc;
      column_in = shift_en ? column_from_right : column_ff;
      acc = '0;
      for (int r = 0; r < TAPS; r++) begin
         prod[r] = $signed({1'b0, column_ff[r]}) * coef[r];
         acc = acc + FILT_W'(prod[r]);
      end
      partial_in = acc;
   end

   always_ff @(posedge clock) begin
      column_ff  <= column_in;
      partial_ff <= partial_in;
   end

   assign column_to_left = column_ff;
   assign partial        = partial_ff;

endmodule

// ===== rtl/cfi_line_buffer.sv =====
// ----------------------------------------------------------------------------
// Line buffer
// One image row of pixels, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cfi_line_buffer import cfi_pkg::*; #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pixel_type         rd_data
);

   pixel_type line_mem [DEPTH];
   pixel_type rd_data_ff;

   // Write port and registered read port; a read sees the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cfi_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Output queue
// Small result queue that decouples the filter pipeline from the receiver.
// ----------------------------------------------------------------------------
module cfi_out_fifo import cfi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  fifo_ctrl_type         ctrl,
   input  result_type            push_result,
   output result_type            head_result,
   output logic [FIFO_CNT_W-1:0] count
);

   result_type              queue_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = ctrl.push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = ctrl.pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (!ctrl.push && ctrl.pop) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         queue_mem[wr_ptr_ff] <= push_result;
      end
   end

   assign head_result = queue_mem[rd_ptr_ff];
   assign count       = count_ff;

endmodule

// ===== rtl/conv3x3_image_filter_unit.sv =====
// ----------------------------------------------------------------------------
// 3x3 image filter unit
// Applies a signed 3x3 kernel to a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on req_if (kind 0 with an 8-bit pixel, kind 1 for a drain
// transaction). Results leave on rsp_if as a 28-bit signed sum and a
// frame_end flag on the last result of the frame. Registers are written on
// csr_if only while the unit is idle, a rule for the user that the unit does
// not enforce: frame width, frame height and three kernel rows of three
// signed 16-bit coefficients each. A geometry write starts a new frame.
// The result for frame pixel n is caused by input pixel n+W+1; border
// results are zero. Once a frame is complete, drain transactions (or further
// pixels) release the last W+1 border results.
// A result passes pipeline stages s1, s2 and s3 into the output queue, which
// offers it on rsp_if.
// Throughput: one transaction per cycle while req_if.ready is high, set by
// the three window cells, each with three multipliers, and the line buffers
// with one write and one read port each.
// If the receiver stalls, results collect in an 8-entry queue and req_if.ready
// drops once queued plus in-flight results reach eight.
// Reset clears the position counters, sets a 100x100 frame and zero kernel;
// line buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module conv3x3_image_filter_unit import cfi_pkg::*; #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic   clock,
   input  logic   reset,
   cfi_req_if.sink   req_if,
   cfi_rsp_if.source rsp_if,
   cfi_csr_if.sink   csr_if
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

   // Tag that travels down the pipeline with each transaction.
   typedef struct packed {
      logic emit;
      logic border;
      logic frame_end;
   } tag_type;

   // Configuration registers.
   logic [GEOM_W-1:0] frame_width_ff, frame_width_in;
   logic [GEOM_W-1:0] frame_height_ff, frame_height_in;
   logic [KROW_W-1:0] kernel_ff [TAPS];
   logic [KROW_W-1:0] kernel_in [TAPS];

   // Position state.
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic             frame_loaded_ff, frame_loaded_in;

   // Pipeline stages.
   logic             s1_shift_ff;
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   tag_type          s1_tag_ff, s2_tag_ff, s3_tag_ff, s0_tag;

   logic [WID_W-1:0] eff_width, in_col_inc, out_col_inc;
   logic [HGT_W-1:0] eff_height, in_row_inc, out_row_inc;
   logic             accept, csr_write, is_pixel, produce, restart;
   logic [FIFO_CNT_W-1:0] queue_count, occupancy;
   pixel_type        upper_rd, middle_rd;
   column_type       new_column;
   column_type       cell_column [TAPS];
   coef_col_type     cell_coef [TAPS];
   filt_type         cell_partial [TAPS];
   filt_type         window_sum;
   fifo_ctrl_type    fifo_ctrl;
   result_type       push_result, head_result;

   // Effective geometry, saturated to the supported range.
   always_comb begin
      if (frame_width_ff < GEOM_W'(MIN_GEOM)) begin
         eff_width = WID_W'(MIN_GEOM);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(frame_width_ff);
      end
      if (frame_height_ff < GEOM_W'(MIN_GEOM)) begin
         eff_height = HGT_W'(MIN_GEOM);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_height = HGT_W'(MAX_HEIGHT);
      end else begin
         eff_height = HGT_W'(frame_height_ff);
      end
   end

   // Handshakes. Room is reserved for every result still in the pipeline.
   assign occupancy = queue_count + FIFO_CNT_W'(s1_tag_ff.emit)
                    + FIFO_CNT_W'(s2_tag_ff.emit) + FIFO_CNT_W'(s3_tag_ff.emit);
   assign req_if.ready = occupancy < FIFO_CNT_W'(FIFO_DEPTH);
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;
   assign csr_write    = csr_if.valid && csr_if.ready;

   // Decode of the incoming transaction against the position counters.
   always_comb begin
      in_col_inc  = WID_W'(in_col_ff) + WID_W'(1);
      in_row_inc  = HGT_W'(in_row_ff) + HGT_W'(1);
      out_col_inc = WID_W'(out_col_ff) + WID_W'(1);
      out_row_inc = HGT_W'(out_row_ff) + HGT_W'(1);
      is_pixel = (req_if.kind == KIND_PIXEL) && !frame_loaded_ff;
      produce  = (in_row_ff >= ROW_W'(2)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
      s0_tag.emit      = is_pixel ? produce : frame_loaded_ff;
      s0_tag.border    = !(out_row_ff != '0 && out_row_inc < eff_height
                           && out_col_ff != '0 && out_col_inc < eff_width);
      s0_tag.frame_end = (out_row_inc >= eff_height) && (out_col_inc >= eff_width);
   end

   // Register writes and position counter updates.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      kernel_in       = kernel_ff;
      in_row_in       = in_row_ff;
      in_col_in       = in_col_ff;
      out_row_in      = out_row_ff;
      out_col_in      = out_col_ff;
      frame_loaded_in = frame_loaded_ff;
      restart         = 1'b0;
      if (csr_write) begin
         case (csr_if.index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_if.data[GEOM_W-1:0];
               restart = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_if.data[GEOM_W-1:0];
               restart = 1'b1;
            end
            REG_KERNEL_TOP:    kernel_in[0] = csr_if.data[KROW_W-1:0];
            REG_KERNEL_MIDDLE: kernel_in[1] = csr_if.data[KROW_W-1:0];
            REG_KERNEL_BOTTOM: kernel_in[2] = csr_if.data[KROW_W-1:0];
            default: ;
         endcase
      end else if (accept) begin
         if (is_pixel) begin
            if (in_col_inc >= eff_width) begin
               in_col_in = '0;
               if (in_row_inc >= eff_height) begin
                  in_row_in       = '0;
                  frame_loaded_in = 1'b1;
               end else begin
                  in_row_in = ROW_W'(in_row_inc);
               end
            end else begin
               in_col_in = COL_W'(in_col_inc);
            end
         end
         if (s0_tag.emit) begin
            if (s0_tag.frame_end) begin
               restart = 1'b1;
            end else if (out_col_inc >= eff_width) begin
               out_col_in = '0;
               out_row_in = ROW_W'(out_row_inc);
            end else begin
               out_col_in = COL_W'(out_col_inc);
            end
         end
      end
      if (restart) begin
         in_row_in       = '0;
         in_col_in       = '0;
         out_row_in      = '0;
         out_col_in      = '0;
         frame_loaded_in = 1'b0;
      end
   end

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DEF_WIDTH;
         frame_height_ff <= DEF_HEIGHT;
         for (int r = 0; r < TAPS; r++) begin
            kernel_ff[r] <= '0;
         end
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         frame_loaded_ff <= 1'b0;
         s1_shift_ff     <= 1'b0;
         s1_tag_ff       <= '0;
         s2_tag_ff       <= '0;
         s3_tag_ff       <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         kernel_ff       <= kernel_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         out_row_ff      <= out_row_in;
         out_col_ff      <= out_col_in;
         frame_loaded_ff <= frame_loaded_in;
         s1_shift_ff     <= accept && is_pixel;
         s1_tag_ff       <= accept ? s0_tag : '0;
         s2_tag_ff       <= s1_tag_ff;
         s3_tag_ff       <= s2_tag_ff;
      end
   end

   // Stage 1 payload: pixel for the new window column and column for the upper line write-back.
   always_ff @(posedge clock) begin
      s1_pixel_ff <= req_if.pixel;
      s1_col_ff   <= in_col_ff;
   end

   // Two line buffers: the middle row is written on each accepted pixel, the
   // upper row takes the old middle pixel in the cycle after.
   cfi_line_buffer #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) u_upper_line (
      .clock   (clock),
      .wr_en   (s1_shift_ff),
      .wr_addr (s1_col_ff),
      .wr_data (middle_rd),
      .rd_en   (accept && is_pixel),
      .rd_addr (in_col_ff),
      .rd_data (upper_rd)
   );

   cfi_line_buffer #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) u_middle_line (
      .clock   (clock),
      .wr_en   (accept && is_pixel),
      .wr_addr (in_col_ff),
      .wr_data (req_if.pixel),
      .rd_en   (accept && is_pixel),
      .rd_addr (in_col_ff),
      .rd_data (middle_rd)
   );

   // New right-hand column of the window and per-column coefficients.
   always_comb begin
      new_column[0] = upper_rd;
      new_column[1] = middle_rd;
      new_column[2] = s1_pixel_ff;
      for (int n = 0; n < TAPS; n++) begin
         for (int r = 0; r < TAPS; r++) begin
            cell_coef[n][r] = kernel_ff[r][n*COEF_W +: COEF_W];
         end
      end
   end

   // Chain of window cells; data moves from the right cell to the left one.
   for (genvar g = 0; g < TAPS; g++) begin : g_cell
      column_type from_right;
      if (g == TAPS - 1) begin : g_edge
         assign from_right = new_column;
      end else begin : g_inner
         assign from_right = cell_column[g+1];
      end
      cfi_cell u_cell (
         .clock             (clock),
         .shift_en          (s1_shift_ff),
         .column_from_right (from_right),
         .coef              (cell_coef[g]),
         .column_to_left    (cell_column[g]),
         .partial           (cell_partial[g])
      );
   end

   // Stage 3: final sum, border forcing and queue write.
   always_comb begin
      window_sum = cell_partial[0] + cell_partial[1] + cell_partial[2];
      push_result.filtered  = s3_tag_ff.border ? '0 : window_sum;
      push_result.frame_end = s3_tag_ff.frame_end;
      fifo_ctrl.push = s3_tag_ff.emit;
      fifo_ctrl.pop  = rsp_if.valid && rsp_if.ready;
   end

   cfi_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (fifo_ctrl),
      .push_result (push_result),
      .head_result (head_result),
      .count       (queue_count)
   );

   assign rsp_if.valid     = queue_count != '0;
   assign rsp_if.filtered  = head_result.filtered;
   assign rsp_if.frame_end = head_result.frame_end;

   // Checks on the pipeline bookkeeping.
   `CFI_ASSERT_NEVER(a_queue_overrun, clock, reset, occupancy > FIFO_CNT_W'(FIFO_DEPTH), "result queue overrun")
   `CFI_ASSERT(a_end_restarts, clock, reset, (accept && !csr_write && s0_tag.emit && s0_tag.frame_end) |=> (in_row_ff == '0 && out_col_ff == '0 && !frame_loaded_ff), "frame end did not restart counters")
   `CFI_ASSERT(a_idle_drain, clock, reset, (accept && req_if.kind == KIND_DRAIN && !frame_loaded_ff) |=> !s1_tag_ff.emit, "drain with nothing pending produced a result")

endmodule

// ===== tb/conv3x3_image_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// 3x3 image filter unit testbench
// Streams frames of random pixels through the filter under several geometry
// and kernel settings. A local line-buffer predictor computes every filtered
// value and frame end flag, and each result transaction is checked in order.
// Both handshake sides stall at random, and the result side is once held off
// long enough to fill the unit and back-pressure the pixel stream.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_unit_tb;
   import cfi_pkg::*;

   localparam int MAX_W            = 128;
   localparam int MAX_H            = 128;
   localparam int SETTLE_CYCLES    = 10;
   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS     = 200;
   localparam int IDLE_PCT         = 20;

   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX_LO = CSR_IDX_W'(REG_KERNEL_BOTTOM + 1);
   localparam logic [CSR_IDX_W-1:0] UNUSED_INDEX_HI = '1;
   localparam logic [COEF_W-1:0]    COEF_MOST_NEGATIVE = 16'h8000;
   localparam logic [COEF_W-1:0]    COEF_MOST_POSITIVE = 16'h7FFF;

   typedef struct packed {
      logic      kind;
      pixel_type pixel;
   } pixel_txn_type;

   logic clock = 1'b0;
   logic reset;

   cfi_req_if req_if ();
   cfi_rsp_if rsp_if ();
   cfi_csr_if csr_if ();

   conv3x3_image_filter_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Testbench bookkeeping.
   pixel_txn_type pending_pixels[$];
   result_type    awaited_results[$];
   int            idle_pct;
   int            hold_requests;
   int            hold_served;
   int            hold_left;
   bit            req_taken;
   int            mismatch_count;
   int            quiet_cycles;
   int            stream_count;
   int unsigned   stim_w;
   int unsigned   stim_h;

   // Shadow of the filter: registers, line buffers, window and positions.
   logic [GEOM_W-1:0] width_reg;
   logic [GEOM_W-1:0] height_reg;
   logic [KROW_W-1:0] kernel_reg [TAPS];
   pixel_type         upper_line [MAX_W];
   pixel_type         middle_line [MAX_W];
   pixel_type         window [TAPS][TAPS];
   int unsigned       in_row, in_col, out_row, out_col;
   bit                frame_loaded;

   always #5 clock = ~clock;

   // Geometry fields outside the supported range are clamped.
   function automatic int unsigned clamp_geometry(logic [GEOM_W-1:0] raw, int unsigned top);
      if (raw < MIN_GEOM) return MIN_GEOM;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   function automatic void restart_frame();
      in_row       = 0;
      in_col       = 0;
      out_row      = 0;
      out_col      = 0;
      frame_loaded = 1'b0;
   endfunction

   function automatic void reset_shadow();
      width_reg  = DEF_WIDTH;
      height_reg = DEF_HEIGHT;
      for (int r = 0; r < TAPS; r++) begin
         kernel_reg[r] = '0;
         for (int n = 0; n < TAPS; n++) window[r][n] = '0;
      end
      for (int c = 0; c < MAX_W; c++) begin
         upper_line[c]  = '0;
         middle_line[c] = '0;
      end
      restart_frame();
   endfunction

   // A geometry write starts a new frame; unknown indexes are ignored.
   function automatic void write_shadow(logic [CSR_IDX_W-1:0] index,
                                        logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_FRAME_WIDTH: begin
            width_reg = value[GEOM_W-1:0];
            restart_frame();
         end
         REG_FRAME_HEIGHT: begin
            height_reg = value[GEOM_W-1:0];
            restart_frame();
         end
         REG_KERNEL_TOP:    kernel_reg[0] = value[KROW_W-1:0];
         REG_KERNEL_MIDDLE: kernel_reg[1] = value[KROW_W-1:0];
         REG_KERNEL_BOTTOM: kernel_reg[2] = value[KROW_W-1:0];
         default: begin
         end
      endcase
   endfunction

   // Produce the output at the current output position and advance it.
   function automatic void emit_filtered(int unsigned w, int unsigned h);
      int         acc;
      result_type res;
      acc = 0;
      if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
         for (int r = 0; r < TAPS; r++)
            for (int n = 0; n < TAPS; n++)
               acc += int'(window[r][n]) * int'(coef_type'(kernel_reg[r][COEF_W*n +: COEF_W]));
      end
      res.filtered  = acc[FILT_W-1:0];
      res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
      awaited_results.push_back(res);
      if (res.frame_end) begin
         restart_frame();
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   // One accepted transaction: shift a pixel in, or release a pending output.
   function automatic void filter_step(logic kind, pixel_type pix);
      int unsigned w, h, col;
      bit          produce;
      w = clamp_geometry(width_reg, MAX_W);
      h = clamp_geometry(height_reg, MAX_H);
      if (kind == KIND_PIXEL && !frame_loaded) begin
         produce = (in_row >= 2) || (in_row == 1 && in_col >= 1);
         col = in_col % MAX_W;
         for (int r = 0; r < TAPS; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
         end
         window[0][2]     = upper_line[col];
         window[1][2]     = middle_line[col];
         window[2][2]     = pix;
         upper_line[col]  = middle_line[col];
         middle_line[col] = pix;
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
               in_row       = 0;
               frame_loaded = 1'b1;
            end
         end else begin
            in_col++;
         end
         if (produce) emit_filtered(w, h);
      end else if (frame_loaded) begin
         emit_filtered(w, h);
      end
   endfunction

   // Pixel driver: holds a transaction until it is taken, idles at random.
   always @(negedge clock) begin
      if (reset || !req_if.valid || req_taken) begin
         if (!reset && pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.kind  <= pending_pixels[0].kind;
            req_if.pixel <= pending_pixels[0].pixel;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Monitor: updates the shadow, checks results and watches for a hang.
   always @(posedge clock) begin : monitor
      result_type oldest;
      bit         rsp_taken;
      bit         csr_taken;
      req_taken = req_if.valid && req_if.ready;
      rsp_taken = rsp_if.valid && rsp_if.ready;
      csr_taken = csr_if.valid && csr_if.ready;
      if (reset) begin
         reset_shadow();
         quiet_cycles = 0;
      end else begin
         if (rsp_taken) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result filtered %0d frame_end %0b",
                        $time, rsp_if.filtered, rsp_if.frame_end);
               mismatch_count++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_if.filtered !== oldest.filtered) begin
                  $display("%0t: filtered mismatch, expected %0d actual %0d",
                           $time, oldest.filtered, rsp_if.filtered);
                  mismatch_count++;
               end
               if (rsp_if.frame_end !== oldest.frame_end) begin
                  $display("%0t: frame_end mismatch, expected %0b actual %0b",
                           $time, oldest.frame_end, rsp_if.frame_end);
                  mismatch_count++;
               end
            end
         end
         if (csr_taken) write_shadow(csr_if.index, csr_if.data);
         if (req_taken) begin
            void'(pending_pixels.pop_front());
            filter_step(req_if.kind, req_if.pixel);
         end
         if (req_taken || rsp_taken || csr_taken) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_geometry(logic [GEOM_W-1:0] w_raw, logic [GEOM_W-1:0] h_raw);
      write_register(REG_FRAME_WIDTH, CSR_DATA_W'(w_raw));
      write_register(REG_FRAME_HEIGHT, CSR_DATA_W'(h_raw));
      stim_w = clamp_geometry(w_raw, MAX_W);
      stim_h = clamp_geometry(h_raw, MAX_H);
   endtask

   task automatic queue_txn(logic kind, pixel_type pix);
      pixel_txn_type t;
      t.kind  = kind;
      t.pixel = pix;
      pending_pixels.push_back(t);
   endtask

   // Pixels of a frame, with stray drain transactions mixed in as noise.
   task automatic queue_pixels(int unsigned count, int noise_pct);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < noise_pct)
            queue_txn(KIND_DRAIN, pixel_type'($urandom_range(255)));
         queue_txn(KIND_PIXEL, pixel_type'($urandom_range(255)));
         stream_count++;
      end
   endtask

   // Release the pending border outputs with drains or surplus pixels.
   task automatic queue_flush(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         queue_txn(1'($urandom_range(1)), pixel_type'($urandom_range(255)));
         stream_count++;
      end
   endtask

   // Wait until every result is in and the pipeline has emptied.
   task automatic settle();
      while (pending_pixels.size() != 0 || awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [GEOM_W-1:0] pick_geometry();
      if ($urandom_range(9) == 0) return GEOM_W'($urandom_range(MIN_GEOM - 1));
      return GEOM_W'($urandom_range(9, MIN_GEOM));
   endfunction

   function automatic logic [KROW_W-1:0] pick_kernel_row();
      case ($urandom_range(3))
         0: return {TAPS{COEF_MOST_NEGATIVE}};
         1: return {TAPS{COEF_MOST_POSITIVE}};
         default: return KROW_W'({$urandom, $urandom});
      endcase
   endfunction

   // Main sequence.
   initial begin
      int random_start;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.kind    = KIND_PIXEL;
      req_if.pixel   = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      idle_pct       = IDLE_PCT;
      hold_requests  = 0;
      hold_served    = 0;
      hold_left      = 0;
      mismatch_count = 0;
      stream_count   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest frame with a too-narrow width field and the most negative
      // kernel; all-white pixels give the lowest possible sum.
      set_geometry(8'd2, 8'd3);
      for (int r = 0; r < TAPS; r++)
         write_register(CSR_IDX_W'(REG_KERNEL_TOP + r), {TAPS{COEF_MOST_NEGATIVE}});
      write_register(UNUSED_INDEX_LO, '1);
      write_register(UNUSED_INDEX_HI, '1);
      queue_txn(KIND_DRAIN, 8'hFF);
      repeat (9) queue_txn(KIND_PIXEL, 8'hFF);
      queue_txn(KIND_PIXEL, 8'h00);
      repeat (3) queue_txn(KIND_DRAIN, 8'h00);
      queue_txn(KIND_DRAIN, 8'h00);
      settle();

      // Same frame with the most positive kernel for the highest sum.
      for (int r = 0; r < TAPS; r++)
         write_register(CSR_IDX_W'(REG_KERNEL_TOP + r), {TAPS{COEF_MOST_POSITIVE}});
      repeat (9) queue_txn(KIND_PIXEL, 8'hFF);
      repeat (4) queue_txn(KIND_DRAIN, 8'h00);
      settle();

      // Receiver holds off while a full frame is offered, so the unit fills.
      set_geometry(8'd5, 8'd5);
      for (int r = 0; r < TAPS; r++)
         write_register(CSR_IDX_W'(REG_KERNEL_TOP + r), pick_kernel_row());
      hold_requests++;
      queue_pixels(25, 0);
      queue_flush(6);
      settle();

      // Widest frame from an all-ones width field and an all-zero height.
      // Two rows and a few pixels reach the first interior result.
      idle_pct = 0;
      set_geometry(8'hFF, 8'h00);
      write_register(REG_KERNEL_MIDDLE, '0);
      queue_pixels(2 * stim_w + 3, 2);
      settle();

      // Random phases: mostly complete frames, some abandoned part way.
      random_start = stream_count;
      while (stream_count - random_start < RANDOM_ITEMS) begin
         idle_pct = ($urandom_range(4) == 0) ? 0 : IDLE_PCT;
         if (stream_count == random_start || $urandom_range(2) != 0)
            set_geometry(pick_geometry(), pick_geometry());
         for (int r = 0; r < TAPS; r++)
            if ($urandom_range(1))
               write_register(CSR_IDX_W'(REG_KERNEL_TOP + r), pick_kernel_row());
         if ($urandom_range(7) == 0)
            write_register(CSR_IDX_W'($urandom_range(UNUSED_INDEX_HI, UNUSED_INDEX_LO)),
                           CSR_DATA_W'({$urandom, $urandom}));
         if ($urandom_range(9) < 7) begin
            repeat ($urandom_range(2, 1)) begin
               queue_pixels(stim_w * stim_h, 5);
               queue_flush(stim_w + 1);
            end
            repeat ($urandom_range(2)) queue_txn(KIND_DRAIN, pixel_type'($urandom_range(255)));
         end else begin
            queue_pixels($urandom_range(stim_w * stim_h - 1, 1), 10);
         end
         settle();
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
